>>> src/flptw_pkg.sv
// Shared types and constants for the four-level page table walker.
`default_nettype none

package flptw_pkg;

  localparam int STORE_WORDS_DEF = 4096;
  localparam int TABLE_ENTRIES   = 512;
  localparam int IDX_W           = 9;
  localparam int PAGE_SHIFT      = 12;
  localparam int ROOT_W          = 3;
  localparam int PAGE_NUM_W      = 64 - PAGE_SHIFT;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NOT_PRESENT = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE     = 2'd2;
  localparam logic [1:0] STATUS_WRITE       = 2'd3;

  localparam logic MODE_WRITE     = 1'b0;
  localparam logic MODE_TRANSLATE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [11:0] word_index;
    logic [63:0] entry_data;
    logic [47:0] vaddr;
  } flptw_req_t;

  typedef struct packed {
    logic [63:0] frame_addr;
    logic [1:0]  status;
  } flptw_rsp_t;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } flptw_state_t;

endpackage

`default_nettype wire

>>> src/four_level_page_table_walker_top.sv
// Four-level page table walker: table store, walk sequencer and result register.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) sets the root table page; it is
//   always ready; the user must write it only while the block is idle, which
//   the block does not enforce. req channel (req_valid/req_stall/req_data)
//   takes one request at a time. A write request stores one 64-bit table
//   word; its result (status 3) appears in the result register in the cycle
//   after acceptance, and a write leaves the block idle. A translate request
//   reads up to four entries from the table store, one per cycle, each address
//   built from the previous entry; the next request is taken only after the
//   walk has loaded its result into the result register.
//   Walks that stop on a not-present entry or an out-of-range page end early.
//   rsp channel (rsp_valid/rsp_stall/rsp_data) holds the result while
//   rsp_stall is high; a finished walk waits and req_stall stays high until
//   the result register can take it.
//   Reset clears the sequencer, the result valid and the root page (to 0);
//   the table store is not cleared and must be written before it is read.
`default_nettype none

module four_level_page_table_walker_top
  import flptw_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output      logic              cfg_ready,
  input  wire logic [ROOT_W-1:0] cfg_data,
  input  wire logic              req_valid,
  output      logic              req_stall,
  input  wire flptw_req_t        req_data,
  output      logic              rsp_valid,
  input  wire logic              rsp_stall,
  output      flptw_rsp_t        rsp_data
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam int PW = (AW > IDX_W) ? (AW - IDX_W) : 1;
  localparam logic [PAGE_NUM_W-1:0] PAGES = PAGE_NUM_W'(STORE_WORDS / TABLE_ENTRIES);
  localparam logic [31:0] STORE_LIMIT = 32'(STORE_WORDS);

  logic [63:0] table_store [STORE_WORDS];

  flptw_state_t      state, state_next;
  logic [1:0]        lvl, lvl_next;
  logic [26:0]       va_lo;
  logic [AW-1:0]     cur_addr;
  logic [63:0]       rd_data;
  logic [ROOT_W-1:0] root_page;

  logic [PAGE_NUM_W-1:0] page_sel;
  logic [IDX_W-1:0]      idx_sel;
  logic                  page_ok;
  logic [PW+IDX_W-1:0]   addr_wide;
  logic [AW-1:0]         walk_addr;
  logic [AW-1:0]         rd_addr;
  logic [31:0]           widx_ext;
  logic                  widx_ok;
  logic                  wr_en;
  logic                  req_fire;
  logic                  rsp_free;
  logic                  rsp_load;
  logic                  walk_done;
  flptw_rsp_t            rsp_next;

  assign cfg_ready = 1'b1;
  assign req_fire  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !rsp_free;

  assign widx_ext = {20'd0, req_data.word_index};
  assign widx_ok  = widx_ext < STORE_LIMIT;

  // Shared page check and address build: root page when idle, entry page during a walk.
  always_comb begin
    if (state == S_IDLE) begin
      page_sel = {{(PAGE_NUM_W-ROOT_W){1'b0}}, root_page};
      idx_sel  = req_data.vaddr[47:39];
    end else begin
      page_sel = rd_data[63:PAGE_SHIFT];
      case (lvl)
        2'd0:    idx_sel = va_lo[26:18];
        2'd1:    idx_sel = va_lo[17:9];
        default: idx_sel = va_lo[8:0];
      endcase
    end
  end

  assign page_ok   = page_sel < PAGES;
  assign addr_wide = {page_sel[PW-1:0], idx_sel};
  assign walk_addr = addr_wide[AW-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire && req_data.mode == MODE_TRANSLATE && page_ok) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_done && rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    rd_addr   = cur_addr;
    wr_en     = 1'b0;
    rsp_load  = 1'b0;
    walk_done = 1'b0;
    lvl_next  = lvl;
    rsp_next  = '{frame_addr: 64'd0, status: STATUS_OK};
    unique case (state)
      S_IDLE: begin
        rd_addr  = walk_addr;
        lvl_next = 2'd0;
        if (req_fire) begin
          if (req_data.mode == MODE_WRITE) begin
            wr_en           = widx_ok;
            rsp_load        = 1'b1;
            rsp_next.status = STATUS_WRITE;
          end else if (!page_ok) begin
            rsp_load        = 1'b1;
            rsp_next.status = STATUS_OUTSIDE;
          end
        end
      end
      S_WALK: begin
        if (lvl == 2'd3) begin
          walk_done           = 1'b1;
          rsp_next.frame_addr = {rd_data[63:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
          rsp_next.status     = STATUS_OK;
        end else if (!rd_data[0]) begin
          walk_done       = 1'b1;
          rsp_next.status = STATUS_NOT_PRESENT;
        end else if (!page_ok) begin
          walk_done       = 1'b1;
          rsp_next.status = STATUS_OUTSIDE;
        end else begin
          rd_addr  = walk_addr;
          lvl_next = lvl + 2'd1;
        end
        rsp_load = walk_done && rsp_free;
      end
      default: begin
        rd_addr = cur_addr;
      end
    endcase
  end

  // Table store: at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_store[widx_ext[AW-1:0]] <= req_data.entry_data;
    end
    rd_data <= table_store[rd_addr];
  end

  // Hold the read address so a stalled walk re-reads the same word
  always_ff @(posedge clk) begin
    cur_addr <= rd_addr;
    lvl      <= lvl_next;
    if (req_fire) begin
      va_lo <= req_data.vaddr[38:12];
    end
    if (rsp_load) begin
      rsp_data <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      root_page <= '0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        root_page <= cfg_data;
      end
    end
  end

`ifndef ASSERT_OFF
  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && req_fire && req_data.mode == MODE_TRANSLATE && page_ok
    |=> state == S_WALK && lvl == 2'd0)
    else $error("translate request did not start a walk at the top level");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && walk_done && rsp_free |=> rsp_valid && state == S_IDLE)
    else $error("finished walk did not deliver a result");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.frame_addr == 64'd0)
    else $error("non-translated result carries a frame address");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Testbench for the four-level page table walker: directed and random walks over a shadow table store.
`timescale 1ns / 1ps

module tb_top;
  import flptw_pkg::*;

  localparam int STORE_PAGES = STORE_WORDS_DEF / TABLE_ENTRIES;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ROOT_W-1:0] cfg_data  = '0;
  logic              req_valid = 1'b0;
  logic              req_stall;
  flptw_req_t        req_data  = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  flptw_rsp_t        rsp_data;

  four_level_page_table_walker_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  // Shadow copy of the table store and the root register
  logic [63:0]       shadow_store   [STORE_WORDS_DEF];
  bit                shadow_written [STORE_WORDS_DEF];
  logic [ROOT_W-1:0] shadow_root = '0;

  flptw_rsp_t  rsp_due [$];
  logic [47:0] va_history [$];
  flptw_rsp_t  want;
  int          error_count = 0;
  int          sent_count  = 0;
  int          idle_pct    = 0;
  int          stall_pct   = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_due.size() == 0) begin
        $error("result with none expected: frame_addr %h status %0d",
               rsp_data.frame_addr, rsp_data.status);
        error_count++;
      end else begin
        want = rsp_due.pop_front();
        if (rsp_data.frame_addr !== want.frame_addr) begin
          $error("frame_addr: expected %h, got %h", want.frame_addr, rsp_data.frame_addr);
          error_count++;
        end
        if (rsp_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_data.status);
          error_count++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Walk the shadow tables; report the first never-written word on the path instead
  function automatic flptw_rsp_t walk_tables(input logic [47:0] va, output int miss_word,
                                             output int miss_lvl);
    flptw_rsp_t  r;
    logic [63:0] pg;
    logic [63:0] ent;
    int          w;
    r         = '0;
    miss_word = -1;
    miss_lvl  = 0;
    pg        = 64'(shadow_root);
    for (int lvl = 0; lvl < 4; lvl++) begin
      if (pg >= STORE_PAGES) begin
        r.status = STATUS_OUTSIDE;
        return r;
      end
      w = int'(pg) * TABLE_ENTRIES + int'(va[39 - IDX_W * lvl +: IDX_W]);
      if (!shadow_written[w]) begin
        miss_word = w;
        miss_lvl  = lvl;
        return r;
      end
      ent = shadow_store[w];
      if (lvl == 3) begin
        r.frame_addr = ent & ~64'hFFF;
        r.status     = STATUS_OK;
        return r;
      end
      if (!ent[0]) begin
        r.status = STATUS_NOT_PRESENT;
        return r;
      end
      pg = ent >> PAGE_SHIFT;
    end
    return r;
  endfunction

  // Mostly present entries pointing inside the store, some absent, some pointing past it
  function automatic logic [63:0] make_entry(input int lvl);
    logic [63:0] e;
    int          pick;
    e    = rand64();
    pick = $urandom_range(99);
    if (lvl == 3) return e;
    if (pick < 84) begin
      e[63:15] = '0;
      e[0]     = 1'b1;
    end else if (pick < 92) begin
      e[0] = 1'b0;
    end else begin
      e[0]                     = 1'b1;
      e[$urandom_range(63, 15)] = 1'b1;
    end
    return e;
  endfunction

  function automatic logic [47:0] pick_va();
    logic [47:0] va;
    logic [47:0] prior;
    int          pick;
    va   = 48'(rand64());
    pick = $urandom_range(99);
    if (va_history.size() == 0 || pick < 25) return va;
    prior = va_history[$urandom_range(va_history.size() - 1)];
    if (pick < 55) return prior;
    if (pick < 80) return {prior[47:21], va[20:0]};
    return {prior[47:30], va[29:0]};
  endfunction

  task automatic send_req(input flptw_req_t item);
    flptw_rsp_t r;
    int         miss_word;
    int         miss_lvl;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    do @(posedge clk); while (req_stall);
    if (item.mode == MODE_WRITE) begin
      if (int'(item.word_index) < STORE_WORDS_DEF) begin
        shadow_store[item.word_index]   = item.entry_data;
        shadow_written[item.word_index] = 1'b1;
      end
      r        = '0;
      r.status = STATUS_WRITE;
    end else begin
      r = walk_tables(item.vaddr, miss_word, miss_lvl);
    end
    rsp_due.push_back(r);
    sent_count++;
  endtask

  task automatic write_word(input logic [11:0] idx, input logic [63:0] data);
    flptw_req_t item;
    item.mode       = MODE_WRITE;
    item.word_index = idx;
    item.entry_data = data;
    item.vaddr      = 48'(rand64());
    send_req(item);
  endtask

  // Fill any never-written word on the path first, then request the translation
  task automatic translate(input logic [47:0] va);
    flptw_req_t item;
    flptw_rsp_t r;
    int         miss_word;
    int         miss_lvl;
    for (int n = 0; n < 8; n++) begin
      r = walk_tables(va, miss_word, miss_lvl);
      if (miss_word < 0) break;
      write_word(12'(miss_word), make_entry(miss_lvl));
    end
    item.mode       = MODE_TRANSLATE;
    item.word_index = 12'($urandom());
    item.entry_data = rand64();
    item.vaddr      = va;
    send_req(item);
    va_history.push_back(va);
    if (va_history.size() > 64) void'(va_history.pop_front());
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_root(input logic [ROOT_W-1:0] pg);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= pg;
    do @(posedge clk); while (!cfg_ready);
    shadow_root = pg;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_write_extremes();
    write_word(12'd4095, '1);
    write_word(12'd0, 64'h0000_0000_0000_1001);
  endtask

  task automatic test_full_walk();
    write_word(12'd1023, 64'h2001);
    write_word(12'd1025, 64'h3001);
    write_word(12'd2047, '1);
    translate({9'd0, 9'd511, 9'd1, 9'd511, 12'hFFF});
    // leaf with its present bit clear still translates
    write_word(12'd2047, 64'h0000_0000_1234_5000);
    translate({9'd0, 9'd511, 9'd1, 9'd511, 12'h000});
    translate(48'h0);
  endtask

  task automatic test_not_present();
    // absent entry pointing past the store: absence wins
    write_word(12'd5, 64'hFFFF_FFFF_FFFF_FFFE);
    translate({9'd5, 39'h0});
    write_word(12'd519, 64'h0);
    translate({9'd0, 9'd7, 30'h0});
    write_word(12'd1033, 64'h2);
    translate({9'd0, 9'd511, 9'd9, 21'h0});
  endtask

  task automatic test_outside();
    write_word(12'd6, 64'h8001);
    translate({9'd6, 39'h0});
    write_word(12'd522, 64'h8000_0000_0000_0001);
    translate({9'd0, 9'd10, 30'h0});
    write_word(12'd1036, 64'h9001);
    translate({9'd0, 9'd511, 9'd12, 21'h0});
  endtask

  task automatic test_root_config();
    set_root(3'd7);
    translate(48'hFFFF_FFFF_FFFF);
    translate({9'd0, 39'h0});
    set_root(3'd0);
    translate({9'd0, 9'd511, 9'd1, 9'd511, 12'h123});
  endtask

  task automatic test_random(input int idle, input int stall, input int n);
    int target;
    int pick;
    set_root(3'($urandom()));
    idle_pct  = idle;
    stall_pct = stall;
    target    = sent_count + n;
    while (sent_count < target) begin
      pick = $urandom_range(99);
      if (pick < 15) write_word(12'($urandom()), rand64());
      else translate(pick_va());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_write_extremes();
    test_full_walk();
    test_not_present();
    test_outside();
    test_root_config();
    test_random(0, 0, 112);
    test_random(54, 0, 112);
    test_random(0, 54, 112);
    test_random(35, 35, 112);
    idle_pct  = 0;
    stall_pct = 0;
    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
